[src/lphm_pkg.sv]
package lphm_pkg;

    localparam int TABLE_SLOTS = 1024;
    localparam int IDX_W       = $clog2(TABLE_SLOTS);
    localparam int OCC_W       = IDX_W + 1;
    localparam int HALF_SLOTS  = TABLE_SLOTS / 2;

    localparam int KEY_W = 64;
    localparam int VAL_W = 64;

    // The low IDX_W bits and the top IDX_W bits of the mixed word are XORed into the slot index.
    localparam int MIX_SHIFT = 29;
    localparam int HASH_W    = MIX_SHIFT + IDX_W;
    localparam int HASH_LO_W = (HASH_W + 1) / 2;
    localparam int HASH_HI_W = HASH_W - HASH_LO_W;
    localparam logic [63:0] MIX_CONST = 64'h9E3779B97F4A7C15;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_FIND   = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic             done;
        logic [IDX_W-1:0] home;
    } hash_rsp_t;

endpackage

[src/linear_probe_hash_map_top.sv]
// Channel  | Signals                                   | Transfer when
// ---------+-------------------------------------------+----------------------
// request  | in_valid, in_ready, req_type, key, value  | in_valid & in_ready
// result   | out_valid, out_ready, status, value_out   | out_valid & out_ready
//
// One request at a time: the accept, key hashing in steps LL, LH, HL and SUM on
// one shared multiplier, then per probed slot a slot memory read, then compare
// and write back, then the load of the result register. After reset a clearing
// pass walks all TABLE_SLOTS slots with in_ready low. A result held by out_ready
// low stalls only the next item's end.
module linear_probe_hash_map_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        req_type,
    input  logic [63:0] key,
    input  logic [63:0] value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [63:0] value_out
);

    localparam int IDX_W = lphm_pkg::IDX_W;
    localparam int OCC_W = lphm_pkg::OCC_W;
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(lphm_pkg::TABLE_SLOTS - 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_HASH  = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_CMP   = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [IDX_W-1:0] clr_reg, clr_next;
    logic [IDX_W-1:0] pos_reg, pos_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic [OCC_W-1:0] occ_reg, occ_next;
    logic             req_reg;
    logic [63:0]      key_reg;
    logic [63:0]      val_reg;
    logic [1:0]       res_status_reg, res_status_next;
    logic [63:0]      res_value_reg, res_value_next;
    logic             out_valid_reg;
    logic [1:0]       status_reg;
    logic [63:0]      value_out_reg;

    logic             accept;
    logic             fin_load;
    logic             hit, empty, miss_all;
    lphm_pkg::hash_rsp_t hash_rsp;

    logic [IDX_W-1:0] ram_addr;
    logic             kram_we, vram_we;
    logic [64:0]      kram_wdata, kram_rdata;
    logic [63:0]      vram_rdata;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign fin_load  = (state_reg == S_FIN) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign value_out = value_out_reg;

    assign empty    = !kram_rdata[64];
    assign hit      = kram_rdata[64] && (kram_rdata[63:0] == key_reg);
    assign miss_all = (cnt_reg == LAST_SLOT);

    lphm_hash u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .key   (key_reg),
        .rsp   (hash_rsp)
    );

    lphm_ram #(
        .WIDTH (65),
        .DEPTH (lphm_pkg::TABLE_SLOTS)
    ) u_key_ram (
        .clk   (clk),
        .we    (kram_we),
        .addr  (ram_addr),
        .wdata (kram_wdata),
        .rdata (kram_rdata)
    );

    lphm_ram #(
        .WIDTH (64),
        .DEPTH (lphm_pkg::TABLE_SLOTS)
    ) u_val_ram (
        .clk   (clk),
        .we    (vram_we),
        .addr  (ram_addr),
        .wdata (val_reg),
        .rdata (vram_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        pos_next        = pos_reg;
        cnt_next        = cnt_reg;
        occ_next        = occ_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        kram_we         = 1'b0;
        vram_we         = 1'b0;
        kram_wdata      = {1'b1, key_reg};
        ram_addr        = pos_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_addr   = clr_reg;
                kram_we    = 1'b1;
                kram_wdata = '0;
                clr_next   = clr_reg + IDX_W'(1);
                if (clr_reg == LAST_SLOT)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                if (hash_rsp.done)
                begin
                    pos_next   = hash_rsp.home;
                    cnt_next   = '0;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (hit || empty || miss_all)
                begin
                    state_next     = S_FIN;
                    res_value_next = '0;
                    if (req_reg == lphm_pkg::REQ_FIND)
                    begin
                        if (hit)
                        begin
                            res_status_next = lphm_pkg::ST_OK;
                            res_value_next  = vram_rdata;
                        end
                        else
                        begin
                            res_status_next = lphm_pkg::ST_NOT_FOUND;
                        end
                    end
                    else if (hit)
                    begin
                        vram_we         = 1'b1;
                        res_status_next = lphm_pkg::ST_OK;
                    end
                    else if (!empty || (occ_reg >= OCC_W'(lphm_pkg::HALF_SLOTS)))
                    begin
                        res_status_next = lphm_pkg::ST_FULL;
                    end
                    else
                    begin
                        kram_we         = 1'b1;
                        vram_we         = 1'b1;
                        occ_next        = occ_reg + OCC_W'(1);
                        res_status_next = lphm_pkg::ST_OK;
                    end
                end
                else
                begin
                    pos_next   = pos_reg + IDX_W'(1);
                    cnt_next   = cnt_reg + IDX_W'(1);
                    state_next = S_READ;
                end
            end
            S_FIN:
            begin
                if (fin_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            occ_reg   <= occ_next;
            if (fin_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        cnt_reg        <= cnt_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        if (accept)
        begin
            req_reg <= req_type;
            key_reg <= key;
            val_reg <= value;
        end
        if (fin_load)
        begin
            status_reg    <= res_status_reg;
            value_out_reg <= res_value_reg;
        end
    end

endmodule

[src/lphm_ram.sv]
module lphm_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [WIDTH-1:0]  wdata,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

[src/lphm_hash.sv]
module lphm_hash (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [63:0]            key,
    output lphm_pkg::hash_rsp_t    rsp
);

    localparam int W  = lphm_pkg::HASH_W;
    localparam int LO = lphm_pkg::HASH_LO_W;
    localparam int HI = lphm_pkg::HASH_HI_W;

    localparam logic [1:0] STEP_LL  = 2'd0;
    localparam logic [1:0] STEP_LH  = 2'd1;
    localparam logic [1:0] STEP_HL  = 2'd2;
    localparam logic [1:0] STEP_SUM = 2'd3;

    localparam logic [LO-1:0] C_LO = lphm_pkg::MIX_CONST[LO-1:0];
    localparam logic [LO-1:0] C_HI = LO'(lphm_pkg::MIX_CONST[W-1:LO]);

    logic          busy_reg, busy_next;
    logic [1:0]    step_reg, step_next;
    logic [LO-1:0] op_a, op_b;
    logic [2*LO-1:0] prod;
    logic [W-1:0]  p_ll_reg;
    logic [HI-1:0] p_x_reg;
    logic [W-1:0]  mix;

    always_comb
    begin
        case (step_reg)
            STEP_LL:
            begin
                op_a = key[LO-1:0];
                op_b = C_LO;
            end
            STEP_LH:
            begin
                op_a = key[LO-1:0];
                op_b = C_HI;
            end
            default:
            begin
                op_a = LO'(key[W-1:LO]);
                op_b = C_LO;
            end
        endcase
    end

    assign prod = op_a * op_b;
    assign mix  = p_ll_reg + {p_x_reg, {LO{1'b0}}};

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_LL;
        end
        else if (busy_reg)
        begin
            step_next = step_reg + 2'd1;
            if (step_reg == STEP_SUM)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= STEP_LL;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            case (step_reg)
                STEP_LL: p_ll_reg <= prod[W-1:0];
                STEP_LH: p_x_reg  <= prod[HI-1:0];
                STEP_HL: p_x_reg  <= p_x_reg + prod[HI-1:0];
                default: ;
            endcase
        end
    end

    assign rsp.done = busy_reg && (step_reg == STEP_SUM);
    assign rsp.home = mix[lphm_pkg::IDX_W-1:0] ^ mix[W-1:lphm_pkg::MIX_SHIFT];

endmodule

[src/lphm_checker.sv]
module lphm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  status,
    input logic [63:0] value_out
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(value_out))
        else $error("result changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == lphm_pkg::ST_OK) || (status == lphm_pkg::ST_NOT_FOUND)
                      || (status == lphm_pkg::ST_FULL))
        else $error("status code out of range");

    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != lphm_pkg::ST_OK) |-> (value_out == 64'd0))
        else $error("nonzero value on a failed request");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second request taken while one is in flight");

endmodule

bind linear_probe_hash_map_top lphm_checker u_lphm_checker (.*);
